// ===== rtl/mk_pkg.sv =====
// Package for the Morse keyer: shared types, constants and the character table lookup.
// Used by every file under rtl; it depends on nothing else.

package mk_pkg;

  localparam int unsigned DOT_W       = 24;
  localparam int unsigned DUR_W       = 27;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned PAT_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DOT_W-1:0] DOT_LENGTH_RESET = 24'd200000;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;

  // Segment length in dot units.
  typedef enum logic [1:0] {
    UNITS_ONE,
    UNITS_THREE,
    UNITS_SEVEN
  } units_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ON,
    BK_OFF
  } back_state_t;

  // One classified character: a word space, or a symbol count and pattern
  // with the first symbol in the most significant used bit (1 = dash).
  typedef struct packed {
    logic             space;
    logic [CNT_W-1:0] count;
    logic [PAT_W-1:0] pattern;
  } sym_entry_t;

  typedef struct packed {
    logic       keep;
    sym_entry_t entry;
  } class_t;

  localparam logic [7:0] ALPHA_TAB [0:25] = '{
    {3'd2, 5'd1},  {3'd4, 5'd8},  {3'd4, 5'd10}, {3'd3, 5'd4},  {3'd1, 5'd0},
    {3'd4, 5'd2},  {3'd3, 5'd6},  {3'd4, 5'd0},  {3'd2, 5'd0},  {3'd4, 5'd7},
    {3'd3, 5'd5},  {3'd4, 5'd4},  {3'd2, 5'd3},  {3'd2, 5'd2},  {3'd3, 5'd7},
    {3'd4, 5'd6},  {3'd4, 5'd13}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
    {3'd3, 5'd1},  {3'd4, 5'd1},  {3'd3, 5'd3},  {3'd4, 5'd9},  {3'd4, 5'd11},
    {3'd4, 5'd12}
  };

  localparam logic [7:0] DIGIT_TAB [0:9] = '{
    {3'd5, 5'd31}, {3'd5, 5'd15}, {3'd5, 5'd7},  {3'd5, 5'd3},  {3'd5, 5'd1},
    {3'd5, 5'd0},  {3'd5, 5'd16}, {3'd5, 5'd24}, {3'd5, 5'd28}, {3'd5, 5'd30}
  };

  function automatic class_t classify(input logic [CHAR_W-1:0] code);
    class_t           res;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] ofs;
    logic [7:0]        e;
    res = '0;
    c   = code;
    e   = '0;
    ofs = '0;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      c = c - CASE_FOLD;
    end
    if (code == CH_SPACE) begin
      res.keep        = 1'b1;
      res.entry.space = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      ofs = c - CH_UPPER_A;
      e   = ALPHA_TAB[ofs[4:0]];
      res.keep = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      ofs = c - CH_ZERO;
      e   = DIGIT_TAB[ofs[3:0]];
      res.keep = 1'b1;
    end
    res.entry.count   = e[7:5];
    res.entry.pattern = e[4:0];
    return res;
  endfunction

endpackage

// ===== rtl/mk_char_if.sv =====
// Input channel of the Morse keyer: one character code per beat.
// Depends on mk_pkg for the field width.

interface mk_char_if;
  logic                      valid;
  logic                      ready;
  logic [mk_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/mk_seg_if.sv =====
// Output channel of the Morse keyer: one LED segment per beat.
// Depends on mk_pkg for the duration width.

interface mk_seg_if;
  logic                     valid;
  logic                     ready;
  logic                     led_level;
  logic [mk_pkg::DUR_W-1:0] duration;
  logic                     last;

  modport source (output valid, output led_level, output duration, output last, input ready);
  modport sink (input valid, input led_level, input duration, input last, output ready);
endinterface

// ===== rtl/mk_front.sv =====
// Front end of the Morse keyer: accepts characters, folds case, looks up the table.
// Unsupported characters are taken and dropped. Depends on mk_pkg and mk_char_if.

module mk_front (
  mk_char_if.sink             char_in,
  input  logic                q_full,
  output logic                q_push,
  output mk_pkg::sym_entry_t  q_data
);

  mk_pkg::class_t cls;

  always_comb begin
    cls = mk_pkg::classify(char_in.char_code);
  end

  assign char_in.ready = !q_full;
  assign q_push        = char_in.valid && !q_full && cls.keep;
  assign q_data        = cls.entry;

endmodule

// ===== rtl/mk_queue.sv =====
// Short queue of classified characters between the front end and the sequencer.
// Depends on mk_pkg for the entry type.

module mk_queue #(
  parameter int unsigned Depth = mk_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mk_pkg::sym_entry_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output mk_pkg::sym_entry_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mk_pkg::sym_entry_t slots [Depth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mk_back.sv =====
// Segment sequencer of the Morse keyer: walks the symbols of one character and
// drives the output register. Depends on mk_pkg and mk_seg_if.

module mk_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mk_pkg::DOT_W-1:0]  dot_length,
  input  logic                      q_not_empty,
  input  mk_pkg::sym_entry_t        q_head,
  output logic                      q_pop,
  mk_seg_if.source                  seg_out
);

  mk_pkg::back_state_t      state;
  mk_pkg::back_state_t      state_next;
  logic [mk_pkg::CNT_W-1:0] cur_count;
  logic [mk_pkg::PAT_W-1:0] cur_pattern;
  logic [mk_pkg::CNT_W-1:0] idx;

  logic                     out_valid;
  logic                     out_level;
  logic [mk_pkg::DUR_W-1:0] out_duration;
  logic                     out_last;

  logic                     advance;
  logic                     emit;
  logic                     capture;
  logic                     seg_level;
  logic                     seg_last;
  mk_pkg::units_t           seg_units;
  logic                     final_sym;
  logic [mk_pkg::CNT_W-1:0] pos;
  logic [mk_pkg::DUR_W-1:0] dur_one;
  logic [mk_pkg::DUR_W-1:0] dur_three;
  logic [mk_pkg::DUR_W-1:0] dur_seven;
  logic [mk_pkg::DUR_W-1:0] seg_duration;

  assign advance   = !out_valid || seg_out.ready;
  assign final_sym = (idx + 1'b1 == cur_count);

  assign dur_one   = mk_pkg::DUR_W'(dot_length);
  assign dur_three = (dur_one << 1) + dur_one;
  assign dur_seven = (dur_one << 3) - dur_one;

  always_comb begin
    state_next = state;
    case (state)
      mk_pkg::BK_IDLE: begin
        if (advance && q_not_empty && !q_head.space) begin
          state_next = mk_pkg::BK_OFF;
        end
      end
      mk_pkg::BK_ON: begin
        if (advance) begin
          state_next = mk_pkg::BK_OFF;
        end
      end
      mk_pkg::BK_OFF: begin
        if (advance) begin
          state_next = final_sym ? mk_pkg::BK_IDLE : mk_pkg::BK_ON;
        end
      end
      default: state_next = mk_pkg::BK_IDLE;
    endcase
  end

  // In IDLE the first on-segment comes straight from the queue head, so a
  // character gives two segments per symbol and a space gives one.
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    capture   = 1'b0;
    seg_level = 1'b0;
    seg_last  = 1'b0;
    seg_units = mk_pkg::UNITS_ONE;
    pos       = '0;
    case (state)
      mk_pkg::BK_IDLE: begin
        if (advance && q_not_empty) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          if (q_head.space) begin
            seg_units = mk_pkg::UNITS_SEVEN;
            seg_last  = 1'b1;
          end else begin
            capture   = 1'b1;
            seg_level = 1'b1;
            pos       = q_head.count - 1'b1;
            seg_units = q_head.pattern[pos] ? mk_pkg::UNITS_THREE : mk_pkg::UNITS_ONE;
          end
        end
      end
      mk_pkg::BK_ON: begin
        emit      = advance;
        seg_level = 1'b1;
        pos       = cur_count - 1'b1 - idx;
        seg_units = cur_pattern[pos] ? mk_pkg::UNITS_THREE : mk_pkg::UNITS_ONE;
      end
      mk_pkg::BK_OFF: begin
        emit      = advance;
        seg_last  = final_sym;
        seg_units = final_sym ? mk_pkg::UNITS_THREE : mk_pkg::UNITS_ONE;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (seg_units)
      mk_pkg::UNITS_ONE:   seg_duration = dur_one;
      mk_pkg::UNITS_THREE: seg_duration = dur_three;
      mk_pkg::UNITS_SEVEN: seg_duration = dur_seven;
      default:             seg_duration = dur_one;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mk_pkg::BK_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= emit;
      end
      if (capture) begin
        idx <= '0;
      end else if (state == mk_pkg::BK_OFF && advance) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cur_count   <= q_head.count;
      cur_pattern <= q_head.pattern;
    end
    if (advance && emit) begin
      out_level    <= seg_level;
      out_duration <= seg_duration;
      out_last     <= seg_last;
    end
  end

  assign seg_out.valid     = out_valid;
  assign seg_out.led_level = out_level;
  assign seg_out.duration  = out_duration;
  assign seg_out.last      = out_last;

endmodule

// ===== rtl/morse_keyer.sv =====
// Top level of the Morse keyer: dot length register, front end, queue and sequencer.
// Depends on mk_pkg, mk_char_if, mk_seg_if, mk_front, mk_queue and mk_back.
//
// Usage:
//   char_in carries one ASCII byte per beat. Letters (either case) and digits
//   become Morse segments; a space becomes one seven-unit off segment; any other
//   byte is accepted and produces nothing.
//   seg_out carries one segment per beat: led_level, duration in ticks and last,
//   which marks the final segment of a character.
//   cfg_we/cfg_data write the dot length in ticks; write only while idle.
// Timing:
//   A character enters the queue in the cycle it is accepted; when the sequencer is
//   idle and the output register can advance, it pops the character and registers
//   its first segment, which is then on seg_out.
//   The sequencer emits one segment per cycle while seg_out is not stalled, so a
//   character with n symbols gives 2n segments (at most 10 for digits) and a space one.
//   The queue holds QueueDepth characters, so the input keeps taking bytes while
//   a character is being played out.
// Reset and stall:
//   rst clears the queue, the sequencer and the output valid, and sets the dot
//   length to 200000 ticks. While seg_out is stalled the output register holds,
//   the sequencer waits, and char_in.ready drops once the queue is full.

module morse_keyer #(
  parameter int unsigned QueueDepth = mk_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  mk_char_if.sink                  char_in,
  mk_seg_if.source                 seg_out,
  input  logic                     cfg_we,
  input  logic [mk_pkg::DOT_W-1:0] cfg_data
);

  logic [mk_pkg::DOT_W-1:0] dot_length;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_not_empty;
  mk_pkg::sym_entry_t       q_in;
  mk_pkg::sym_entry_t       q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_length <= mk_pkg::DOT_LENGTH_RESET;
    end else if (cfg_we) begin
      dot_length <= cfg_data;
    end
  end

  mk_front u_front (
    .char_in (char_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  mk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .dot_length  (dot_length),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .seg_out     (seg_out)
  );

endmodule

// ===== verif/tb_morse_keyer.sv =====
// Self-checking testbench for morse_keyer: directed and random bursts, checked segment by segment.
// Depends on mk_pkg, mk_char_if, mk_seg_if and the morse_keyer RTL.

module tb_morse_keyer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF         = 5;
  localparam int unsigned RESET_CYCLES     = 7;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned HOLD_AFTER_BEATS = 25;
  localparam int unsigned DOT_UNITS        = 1;
  localparam int unsigned DASH_UNITS       = 3;
  localparam int unsigned LETTER_GAP_UNITS = 3;
  localparam int unsigned WORD_GAP_UNITS   = 7;
  localparam logic [mk_pkg::DOT_W-1:0] DOT_MAX = '1;

  typedef enum {RX_FREE, RX_RANDOM, RX_COMB} rx_mode_t;

  // Expected segments of every accepted character, oldest first.
  class segment_ledger;
    typedef struct {
      logic                     level;
      logic [mk_pkg::DUR_W-1:0] ticks;
      logic                     last;
    } segment_t;

    segment_t                 due_segments[$];
    logic [mk_pkg::DOT_W-1:0] dot_ticks;
    string                    letters[26];
    string                    digits[10];
    int                       errors;

    function new();
      dot_ticks = mk_pkg::DOT_LENGTH_RESET;
      errors    = 0;
      letters   = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
      digits    = '{"-----", ".----", "..---", "...--", "....-",
                    ".....", "-....", "--...", "---..", "----."};
    endfunction

    function void set_dot(logic [mk_pkg::DOT_W-1:0] value);
      dot_ticks = value;
    endfunction

    function void push(logic level, int unsigned units, logic last);
      segment_t s;
      s.level = level;
      s.ticks = mk_pkg::DUR_W'(dot_ticks * units);
      s.last  = last;
      due_segments.push_back(s);
    endfunction

    function void note_char(logic [mk_pkg::CHAR_W-1:0] code);
      logic [mk_pkg::CHAR_W-1:0] c;
      string                     marks;
      int                        n;
      c     = code;
      marks = "";
      if (code == mk_pkg::CH_SPACE) begin
        push(1'b0, WORD_GAP_UNITS, 1'b1);
        return;
      end
      if (c >= mk_pkg::CH_LOWER_A && c <= mk_pkg::CH_LOWER_Z) begin
        c = c - mk_pkg::CASE_FOLD;
      end
      if (c >= mk_pkg::CH_UPPER_A && c <= mk_pkg::CH_UPPER_Z) begin
        marks = letters[c - mk_pkg::CH_UPPER_A];
      end else if (c >= mk_pkg::CH_ZERO && c <= mk_pkg::CH_NINE) begin
        marks = digits[c - mk_pkg::CH_ZERO];
      end
      n = marks.len();
      for (int i = 0; i < n; i++) begin
        push(1'b1, (marks[i] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0);
        push(1'b0, (i == n - 1) ? LETTER_GAP_UNITS : DOT_UNITS, i == n - 1);
      end
    endfunction

    function void check_segment(logic level, logic [mk_pkg::DUR_W-1:0] ticks, logic last);
      segment_t want;
      if (due_segments.size() == 0) begin
        $error("unexpected segment: led_level %0d duration %0d last %0d", level, ticks, last);
        errors++;
        return;
      end
      want = due_segments.pop_front();
      if (level !== want.level) begin
        $error("led_level: expected %0d, got %0d", want.level, level);
        errors++;
      end
      if (ticks !== want.ticks) begin
        $error("duration: expected %0d, got %0d", want.ticks, ticks);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we;
  logic [mk_pkg::DOT_W-1:0] cfg_data;

  mk_char_if char_if();
  mk_seg_if  seg_if();

  segment_ledger ledger = new();
  int unsigned   seg_beats = 0;

  morse_keyer DUT (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_if),
    .seg_out  (seg_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Mostly letters and digits so that the sequencer stays busy; the rest is space and noise.
  function automatic logic [mk_pkg::CHAR_W-1:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return mk_pkg::CHAR_W'(mk_pkg::CH_UPPER_A + $urandom_range(0, 25));
    if (roll < 65) return mk_pkg::CHAR_W'(mk_pkg::CH_LOWER_A + $urandom_range(0, 25));
    if (roll < 82) return mk_pkg::CHAR_W'(mk_pkg::CH_ZERO + $urandom_range(0, 9));
    if (roll < 90) return mk_pkg::CH_SPACE;
    return mk_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_char(input logic [mk_pkg::CHAR_W-1:0] code);
    char_if.valid     <= 1'b1;
    char_if.char_code <= code;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    ledger.note_char(code);
  endtask

  task automatic send_random(input int count);
    int burst;
    int gap;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && k < count) begin
        send_char(pick_char());
        burst--;
        k++;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and let every expected segment come out, then let the queue settle.
  task automatic drain();
    char_if.valid <= 1'b0;
    while (ledger.due_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dot(input logic [mk_pkg::DOT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ledger.set_dot(value);
  endtask

  // Result side: checks each beat and then picks the next ready value.
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned rx_cycle;
    logic        rdy;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rx_cycle  = 0;
    seg_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!rst && seg_if.valid && seg_if.ready) begin
        ledger.check_segment(seg_if.led_level, seg_if.duration, seg_if.last);
        seg_beats++;
      end
      if (rst) begin
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && seg_beats >= HOLD_AFTER_BEATS) begin
        // One long hold-off while the sender keeps pushing, so the queue fills.
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
        rdy       = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          RX_FREE:   rdy = 1'b1;
          RX_RANDOM: rdy = 1'($urandom_range(0, 1));
          default:   rdy = (rx_cycle % 4) != 3;
        endcase
      end
      seg_if.ready <= rdy;
    end
  end

  initial begin
    logic [mk_pkg::CHAR_W-1:0] directed[$];
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the alphabet in both cases, digit ends, single-symbol letters,
    // the space, and bytes just outside every accepted range.
    directed = '{mk_pkg::CH_SPACE, mk_pkg::CH_UPPER_A, mk_pkg::CH_LOWER_A,
                 mk_pkg::CH_UPPER_Z, mk_pkg::CH_LOWER_Z, mk_pkg::CH_ZERO, mk_pkg::CH_NINE,
                 8'h45, 8'h54, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h40, 8'h5B, 8'h60, 8'h7B,
                 8'h2F, 8'h3A, 8'h1F, 8'h21, 8'h51, 8'h35};
    foreach (directed[i]) begin
      send_char(directed[i]);
    end
    send_random(20);
    drain();
    send_random(7);

    drain();
    write_dot(24'd1);
    send_random(14);

    drain();
    write_dot(DOT_MAX);
    send_random(14);

    // A zero dot length is honored as written: every segment lasts zero ticks.
    drain();
    write_dot('0);
    send_random(14);

    drain();
    write_dot(mk_pkg::DOT_W'($urandom_range(1, DOT_MAX)));
    send_random(14);

    drain();
    write_dot(mk_pkg::DOT_W'($urandom_range(2, 20)));
    send_random(14);

    drain();
    if (ledger.errors == 0) begin
      $display("tb_morse_keyer OK");
    end else begin
      $display("tb_morse_keyer NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_morse_keyer NOT OK");
    $finish;
  end

endmodule

// ===== morse_keyer.f =====
rtl/mk_pkg.sv
rtl/mk_char_if.sv
rtl/mk_seg_if.sv
rtl/mk_front.sv
rtl/mk_queue.sv
rtl/mk_back.sv
rtl/morse_keyer.sv
verif/tb_morse_keyer.sv
